// ===== hw/rtl/dts_pkg.sv =====
// dts_pkg: types and constants for the datalog token scanner
// depends on nothing

package dts_pkg;

   localparam int unsigned KIND_BITS = 4;
   localparam int unsigned LEN_BITS = 12;
   localparam int unsigned TOTAL_BITS = 32;
   localparam int unsigned MAX_RESULTS = 3;

   localparam logic [1:0] CMD_CHAR = 2'd0;
   localparam logic [1:0] CMD_EOL = 2'd1;
   localparam logic [1:0] CMD_EOF = 2'd2;

   localparam logic [3:0] KIND_COMMA = 4'd0;
   localparam logic [3:0] KIND_PERIOD = 4'd1;
   localparam logic [3:0] KIND_QMARK = 4'd2;
   localparam logic [3:0] KIND_LPAREN = 4'd3;
   localparam logic [3:0] KIND_RPAREN = 4'd4;
   localparam logic [3:0] KIND_COLON = 4'd5;
   localparam logic [3:0] KIND_COLON_DASH = 4'd6;
   localparam logic [3:0] KIND_SCHEMES = 4'd7;
   localparam logic [3:0] KIND_FACTS = 4'd8;
   localparam logic [3:0] KIND_RULES = 4'd9;
   localparam logic [3:0] KIND_QUERIES = 4'd10;
   localparam logic [3:0] KIND_ID = 4'd11;
   localparam logic [3:0] KIND_STRING = 4'd12;
   localparam logic [3:0] KIND_TOTAL = 4'd13;
   localparam logic [3:0] KIND_INPUT_ERROR = 4'd14;
   localparam logic [3:0] KIND_STRING_ERROR = 4'd15;

   localparam logic [7:0] CH_HASH = 8'h23;
   localparam logic [7:0] CH_QUOTE = 8'h27;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DASH = 8'h2D;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_PERIOD = 8'h2E;
   localparam logic [7:0] CH_QMARK = 8'h3F;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_TAB = 8'h09;

   localparam logic [63:0] KW_SCHEMES = 64'h0053_6368_656D_6573;
   localparam logic [63:0] KW_FACTS = 64'h0000_0046_6163_7473;
   localparam logic [63:0] KW_RULES = 64'h0000_0052_756C_6573;
   localparam logic [63:0] KW_QUERIES = 64'h0051_7565_7269_6573;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] ch;
   } req_type;

endpackage

// ===== hw/rtl/dts_stream_if.sv =====
// dts_stream_if: valid/ready channel carrying a generic payload
// depends on nothing

interface dts_stream_if #(
   parameter int unsigned WIDTH = 10
) ();
   logic             valid;
   logic             ready;
   logic [WIDTH-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/dts_front.sv =====
// dts_front: accepts items and buffers them in a short queue
// depends on dts_pkg

module dts_front #(
   parameter int unsigned DEPTH_BITS = 1
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   output logic             in_ready,
   input  dts_pkg::req_type in_data,
   output logic             q_valid,
   input  logic             q_ready,
   output dts_pkg::req_type q_data
);
   import dts_pkg::*;

   localparam int unsigned DEPTH = 1 << DEPTH_BITS;

   req_type               mem_ff [DEPTH];
   logic [DEPTH_BITS-1:0] wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [DEPTH_BITS:0]   count_ff, count_in;
   logic                  push, pop;

   assign in_ready = (count_ff != (DEPTH_BITS+1)'(DEPTH));
   assign q_valid = (count_ff != '0);
   assign q_data = mem_ff[rptr_ff];
   assign push = in_valid && in_ready;
   assign pop = q_valid && q_ready;

   always_comb begin
      wptr_in = push ? wptr_ff + 1'b1 : wptr_ff;
      rptr_in = pop ? rptr_ff + 1'b1 : rptr_ff;
      count_in = count_ff + (DEPTH_BITS+1)'(push) - (DEPTH_BITS+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= '0;
         rptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         count_ff <= count_in;
      end
   end
endmodule

// ===== hw/rtl/dts_back.sv =====
// dts_back: scanner state, classification, and a three-slot result buffer
// depends on dts_pkg

module dts_back #(
   parameter int unsigned LINE_BITS = 16,
   parameter int unsigned COLUMN_BITS = 12,
   parameter int unsigned KEYWORD_CHARS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_valid,
   output logic                   q_ready,
   input  dts_pkg::req_type       q_data,
   output logic                   out_valid,
   input  logic                   out_ready,
   output logic [3:0]             out_kind,
   output logic [LINE_BITS-1:0]   out_line,
   output logic [COLUMN_BITS-1:0] out_column,
   output logic [COLUMN_BITS-1:0] out_length,
   output logic [31:0]            out_total,
   output logic                   out_last
);
   import dts_pkg::*;

   localparam int unsigned PB = 8 * KEYWORD_CHARS;
   localparam logic [LINE_BITS-1:0] LSAT = '1;
   localparam logic [COLUMN_BITS-1:0] CSAT = '1;

   typedef struct packed {
      logic [3:0]             kind;
      logic [LINE_BITS-1:0]   line;
      logic [COLUMN_BITS-1:0] column;
      logic [COLUMN_BITS-1:0] length;
      logic [31:0]            total;
   } rec_type;

   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] col_ff, col_in;
   logic [PB-1:0]          pre_ff, pre_in;
   logic [COLUMN_BITS-1:0] idl_ff, idl_in, ids_ff, ids_in;
   logic [COLUMN_BITS-1:0] sl_ff, sl_in, ss_ff, ss_in;
   logic                   sm_ff, sm_in, cp_ff, cp_in, qp_ff, qp_in;
   logic                   cm_ff, cm_in, halt_ff, halt_in;
   logic [31:0]            tc_ff, tc_in;

   rec_type    buf_ff [MAX_RESULTS];
   rec_type    rec [MAX_RESULTS];
   logic [1:0] n_ff, n_in, pos_ff, pos_in, n;
   logic       busy;

   function automatic logic [31:0] sat_inc(logic [31:0] v);
      return (v != 32'hFFFF_FFFF) ? v + 32'd1 : v;
   endfunction

   assign busy = (n_ff != 2'd0);
   assign q_ready = !busy || (out_ready && pos_ff + 2'd1 == n_ff);
   assign out_valid = busy;
   assign out_kind = buf_ff[pos_ff].kind;
   assign out_line = buf_ff[pos_ff].line;
   assign out_column = buf_ff[pos_ff].column;
   assign out_length = buf_ff[pos_ff].length;
   assign out_total = buf_ff[pos_ff].total;
   assign out_last = (pos_ff + 2'd1 == n_ff);

   always_comb begin
      logic [LINE_BITS-1:0]   cl;
      logic [7:0]             c;
      logic                   alpha, digit, done, eol;
      logic                   str_tok, col_tok, dash_tok, fl_tok, pun_tok, err_tok, tot_tok;
      logic [3:0]             pun_kind, err_kind, id_kind;
      logic [COLUMN_BITS-1:0] str_len;
      logic [63:0]            pk;
      line_in = line_ff; col_in = col_ff; pre_in = pre_ff; idl_in = idl_ff;
      ids_in = ids_ff; sl_in = sl_ff; ss_in = ss_ff; sm_in = sm_ff; cp_in = cp_ff;
      qp_in = qp_ff; cm_in = cm_ff; halt_in = halt_ff; tc_in = tc_ff;
      n = 2'd0; done = 1'b0; eol = 1'b0;
      str_tok = 1'b0; col_tok = 1'b0; dash_tok = 1'b0; fl_tok = 1'b0;
      pun_tok = 1'b0; err_tok = 1'b0; tot_tok = 1'b0;
      pun_kind = KIND_COMMA; err_kind = KIND_INPUT_ERROR; str_len = sl_ff;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         rec[i] = '0;
      end
      cl = (line_ff != LSAT) ? line_ff + 1'b1 : LSAT;
      c = q_data.ch;
      alpha = (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
      digit = (c >= 8'h30 && c <= 8'h39);

      // keyword match on the open identifier
      pk = '0;
      pk[PB-1:0] = pre_ff;
      id_kind = KIND_ID;
      if (idl_ff == COLUMN_BITS'(7) && pk == KW_SCHEMES) id_kind = KIND_SCHEMES;
      if (idl_ff == COLUMN_BITS'(5) && pk == KW_FACTS) id_kind = KIND_FACTS;
      if (idl_ff == COLUMN_BITS'(5) && pk == KW_RULES) id_kind = KIND_RULES;
      if (idl_ff == COLUMN_BITS'(7) && pk == KW_QUERIES) id_kind = KIND_QUERIES;

      if (!halt_ff) begin
         case (q_data.cmd)
            CMD_CHAR: begin
               if (col_ff != CSAT) col_in = col_ff + 1'b1;
               if (!cm_ff) begin
                  if (qp_ff) begin
                     qp_in = 1'b0;
                     if (c == CH_QUOTE) begin
                        str_tok = 1'b1; str_len = '0;
                        done = 1'b1;
                     end else begin
                        sm_in = 1'b1; sl_in = '0;
                     end
                  end
                  if (!done && sm_in) begin
                     done = 1'b1;
                     if (c == CH_QUOTE) begin
                        str_tok = 1'b1; str_len = sl_in;
                        sm_in = 1'b0; sl_in = '0;
                     end else if ((c >= 8'h20 && c <= 8'h7E) || c == CH_TAB) begin
                        if (sl_in != CSAT) sl_in = sl_in + 1'b1;
                     end else begin
                        err_tok = 1'b1; err_kind = KIND_STRING_ERROR;
                     end
                  end
                  if (!done && cp_ff) begin
                     cp_in = 1'b0;
                     if (c == CH_DASH) begin
                        dash_tok = 1'b1;
                        done = 1'b1;
                     end else begin
                        col_tok = 1'b1;
                     end
                  end
                  if (!done) begin
                     done = 1'b1;
                     case (c)
                        CH_HASH: begin fl_tok = 1'b1; cm_in = 1'b1; end
                        CH_QUOTE: begin fl_tok = 1'b1; qp_in = 1'b1; ss_in = col_ff; end
                        CH_COMMA: begin fl_tok = 1'b1; pun_tok = 1'b1; pun_kind = KIND_COMMA; end
                        CH_PERIOD: begin fl_tok = 1'b1; pun_tok = 1'b1; pun_kind = KIND_PERIOD; end
                        CH_QMARK: begin fl_tok = 1'b1; pun_tok = 1'b1; pun_kind = KIND_QMARK; end
                        CH_LPAREN: begin fl_tok = 1'b1; pun_tok = 1'b1; pun_kind = KIND_LPAREN; end
                        CH_RPAREN: begin fl_tok = 1'b1; pun_tok = 1'b1; pun_kind = KIND_RPAREN; end
                        CH_COLON: begin fl_tok = 1'b1; cp_in = 1'b1; ids_in = col_ff; end
                        CH_DASH, 8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D: begin fl_tok = 1'b1; end
                        default: done = 1'b0;
                     endcase
                     if (fl_tok) begin
                        idl_in = '0; pre_in = '0;
                     end
                  end
                  if (!done) begin
                     if (idl_ff != '0 && (alpha || digit)) begin
                        if (idl_ff < COLUMN_BITS'(KEYWORD_CHARS)) pre_in = {pre_ff[PB-9:0], c};
                        if (idl_ff != CSAT) idl_in = idl_ff + 1'b1;
                     end else begin
                        fl_tok = 1'b1; idl_in = '0; pre_in = '0;
                        if (alpha) begin
                           ids_in = col_ff; idl_in = COLUMN_BITS'(1); pre_in = PB'(c);
                        end else if (c >= 8'h21 && c <= 8'h7E) begin
                           err_tok = 1'b1; err_kind = KIND_INPUT_ERROR;
                        end
                     end
                  end
               end
            end
            CMD_EOL: eol = 1'b1;
            CMD_EOF: begin
               eol = (col_ff != '0);
               tot_tok = 1'b1;
            end
            default: ;
         endcase
         if (eol) begin
            if (cp_ff) begin
               cp_in = 1'b0; col_tok = 1'b1;
            end
            if (qp_ff || sm_ff) begin
               err_tok = 1'b1; err_kind = KIND_STRING_ERROR;
            end else begin
               fl_tok = 1'b1; idl_in = '0; pre_in = '0;
               cm_in = 1'b0; col_in = '0;
               if (line_ff != LSAT) line_in = line_ff + 1'b1;
            end
         end
         if (err_tok) halt_in = 1'b1;
      end

      // records in emission order
      fl_tok = fl_tok && (idl_ff != '0);
      tot_tok = tot_tok && !err_tok;
      if (str_tok) begin
         rec[n] = '{KIND_STRING, cl, ss_ff, str_len, 32'd0}; n = n + 2'd1;
         tc_in = sat_inc(tc_in);
      end
      if (col_tok) begin
         rec[n] = '{KIND_COLON, cl, ids_ff, COLUMN_BITS'(1), 32'd0}; n = n + 2'd1;
         tc_in = sat_inc(tc_in);
      end
      if (dash_tok) begin
         rec[n] = '{KIND_COLON_DASH, cl, ids_ff, COLUMN_BITS'(2), 32'd0}; n = n + 2'd1;
         tc_in = sat_inc(tc_in);
      end
      if (fl_tok) begin
         rec[n] = '{id_kind, cl, ids_ff, idl_ff, 32'd0}; n = n + 2'd1;
         tc_in = sat_inc(tc_in);
      end
      if (pun_tok) begin
         rec[n] = '{pun_kind, cl, col_ff, COLUMN_BITS'(1), 32'd0}; n = n + 2'd1;
         tc_in = sat_inc(tc_in);
      end
      if (err_tok) begin
         rec[n] = '{err_kind, cl, col_ff, '0, 32'd0}; n = n + 2'd1;
      end
      if (tot_tok) begin
         rec[n] = '{KIND_TOTAL, line_in, '0, '0, tc_in}; n = n + 2'd1;
      end
   end

   always_comb begin
      n_in = n_ff; pos_in = pos_ff;
      if (busy && out_ready) begin
         if (pos_ff + 2'd1 == n_ff) begin n_in = 2'd0; pos_in = 2'd0; end
         else pos_in = pos_ff + 2'd1;
      end
      if (q_valid && q_ready && n != 2'd0) begin
         n_in = n; pos_in = 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (q_valid && q_ready) begin
         for (int i = 0; i < MAX_RESULTS; i++) begin
            buf_ff[i] <= rec[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         line_ff <= '0; col_ff <= '0; pre_ff <= '0; idl_ff <= '0; ids_ff <= '0;
         sl_ff <= '0; ss_ff <= '0; sm_ff <= 1'b0; cp_ff <= 1'b0; qp_ff <= 1'b0;
         cm_ff <= 1'b0; halt_ff <= 1'b0; tc_ff <= '0; n_ff <= '0; pos_ff <= '0;
      end else begin
         if (q_valid && q_ready) begin
            line_ff <= line_in; col_ff <= col_in; pre_ff <= pre_in; idl_ff <= idl_in;
            ids_ff <= ids_in; sl_ff <= sl_in; ss_ff <= ss_in; sm_ff <= sm_in;
            cp_ff <= cp_in; qp_ff <= qp_in; cm_ff <= cm_in; halt_ff <= halt_in;
            tc_ff <= tc_in;
         end
         n_ff <= n_in; pos_ff <= pos_in;
      end
   end
endmodule

// ===== hw/rtl/datalog_token_scanner.sv =====
// datalog_token_scanner: top level, queue front end and scanning back end
// depends on dts_pkg, dts_stream_if, dts_front, dts_back
//
// req channel carries one item per transfer: cmd (character, end of line,
// end of file) and ch. rsp channel carries token records: kind, line,
// column, length, token_total, and last on the final record of an item.
// An item enters a two-entry queue, then the scanner classifies it and
// loads up to three records into a result buffer; the queue and then the
// result buffer register lie between req and rsp. One item per cycle is
// sustained while each item yields at most one record and rsp is ready; an
// item with more records holds the scanner until rsp has taken its last.
// A stalled rsp fills the queue, after which req_ready drops.
// Reset clears all counters, flags and the queue. After an error record
// the block drops every item without a result until reset.

module datalog_token_scanner #(
   parameter int unsigned LINE_BITS = 16,
   parameter int unsigned COLUMN_BITS = 12,
   parameter int unsigned KEYWORD_CHARS = 7
) (
   input  logic                   clock,
   input  logic                   reset,
   dts_stream_if.sink             req,
   dts_stream_if.source           rsp
);
   import dts_pkg::*;

   logic       q_valid, q_ready;
   req_type    q_data, req_data;
   logic [3:0]             rsp_kind;
   logic [LINE_BITS-1:0]   rsp_line;
   logic [COLUMN_BITS-1:0] rsp_column, rsp_length;
   logic [31:0]            rsp_token_total;
   logic                   rsp_last;

   assign req_data = req_type'(req.data[9:0]);
   assign rsp.data = {rsp_kind, rsp_line, rsp_column, rsp_length, rsp_token_total, rsp_last};

   dts_front #(.DEPTH_BITS(1)) u_front (
      .clock(clock), .reset(reset), .in_valid(req.valid), .in_ready(req.ready),
      .in_data(req_data), .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
   );

   dts_back #(
      .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .KEYWORD_CHARS(KEYWORD_CHARS)
   ) u_back (
      .clock(clock), .reset(reset), .q_valid(q_valid), .q_ready(q_ready),
      .q_data(q_data), .out_valid(rsp.valid), .out_ready(rsp.ready),
      .out_kind(rsp_kind), .out_line(rsp_line), .out_column(rsp_column),
      .out_length(rsp_length), .out_total(rsp_token_total), .out_last(rsp_last)
   );

   a_last_ends: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp.ready && !rsp_last |=> rsp.valid)
      else $error("record stream ended without last");
   a_total_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && rsp_kind == KIND_TOTAL |-> rsp_last)
      else $error("total record not last");
   a_error_last: assert property (@(posedge clock) disable iff (reset)
      rsp.valid && (rsp_kind == KIND_INPUT_ERROR || rsp_kind == KIND_STRING_ERROR)
      |-> rsp_last)
      else $error("error record not last");
endmodule
